// ===== hw/rtl/sg_pkg.sv =====
package sg_pkg;

  localparam int SEED_BYTES = 24;
  localparam int SEED_BITS  = SEED_BYTES * 8;
  localparam int POS_W      = $clog2(SEED_BITS);
  localparam int IDX_W      = 5;
  localparam int TAP_N      = 4;
  localparam int POLY_COUNT = 16;
  localparam int SEL_W      = 4;
  localparam int MAX_BITS   = 32;
  localparam int CNT_W      = 6;

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_GEN    = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic {
    REG_POLY_A = 1'b0,
    REG_POLY_B = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
  } cell_ctl_t;

  typedef logic [POS_W-1:0] tap_t;

  // Sparse tap lists; the first entry is the degree.
  localparam tap_t TAPS [POLY_COUNT][TAP_N] = '{
    '{8'd162, 8'd161, 8'd75,  8'd74 }, '{8'd114, 8'd14,  8'd0,   8'd0  },
    '{8'd115, 8'd70,  8'd69,  8'd0  }, '{8'd116, 8'd19,  8'd17,  8'd1  },
    '{8'd117, 8'd23,  8'd0,   8'd0  }, '{8'd118, 8'd7,   8'd0,   8'd0  },
    '{8'd119, 8'd117, 8'd110, 8'd6  }, '{8'd164, 8'd163, 8'd151, 8'd150},
    '{8'd121, 8'd69,  8'd58,  8'd0  }, '{8'd122, 8'd1,   8'd0,   8'd0  },
    '{8'd166, 8'd165, 8'd128, 8'd127}, '{8'd124, 8'd107, 8'd106, 8'd0  },
    '{8'd125, 8'd36,  8'd35,  8'd0  }, '{8'd168, 8'd166, 8'd153, 8'd151},
    '{8'd127, 8'd28,  8'd26,  8'd1  }, '{8'd128, 8'd4,   8'd0,   8'd0  }
  };

  localparam logic [2:0] TAP_COUNT [POLY_COUNT] = '{
    3'd4, 3'd3, 3'd4, 3'd4, 3'd2, 3'd3, 3'd4, 3'd4,
    3'd4, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2
  };

endpackage

// ===== hw/rtl/sg_cell.sv =====
module sg_cell
  import sg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      sel,
  input  logic [7:0] seed_byte,
  input  logic      carry_in,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      q <= '0;
    end else if (ctl.load && sel) begin
      q <= seed_byte;
    end else if (ctl.shift) begin
      q <= {q[6:0], carry_in};
    end
  end

endmodule

// ===== hw/rtl/sg_lfsr.sv =====
module sg_lfsr
  import sg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] byte_index,
  input  logic [7:0]       seed_byte,
  input  logic [SEL_W-1:0] poly,
  output logic             next_bit,
  output logic             dead
);

  logic [SEED_BITS-1:0] bits;
  logic [7:0]           cell_q [SEED_BYTES];
  logic                 fb;
  logic [SEED_BITS-1:0] window;
  tap_t                 deg;

  assign deg = TAPS[poly][0];

  always_comb begin
    fb = 1'b0;
    for (int i = 0; i < TAP_N; i++) begin
      if (3'(i) < TAP_COUNT[poly]) begin
        fb = fb ^ bits[TAPS[poly][i]];
      end
    end
  end

  // bit at the degree after this clock is the bit just below it now
  assign next_bit = bits[deg - tap_t'(1)];

  always_comb begin
    for (int n = 0; n < SEED_BITS; n++) begin
      window[n] = (POS_W'(n) <= deg);
    end
  end

  assign dead = ~|(bits & window);

  for (genvar k = 0; k < SEED_BYTES; k++) begin : g_cell
    logic cin;
    if (k == 0) begin : g_first
      assign cin = fb;
    end else begin : g_rest
      assign cin = cell_q[k-1][7];
    end

    sg_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .sel       (byte_index == IDX_W'(k)),
      .seed_byte (seed_byte),
      .carry_in  (cin),
      .q         (cell_q[k])
    );

    assign bits[8*k +: 8] = cell_q[k];
  end

endmodule

// ===== hw/rtl/shrinking_generator_dual_lfsr.sv =====
// Load and clear items give no result.
// A generate item is accepted, then both LFSRs are clocked until A has given a one
// for each requested bit, and the word is posted to the output register.
// A count of zero or an all-zero A window gives a zero word.
// Reset (rst, synchronous) clears both seeds, sets poly A select to 0, B to 1.
module shrinking_generator_dual_lfsr
  import sg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [SEL_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       action,
  input  logic [IDX_W-1:0] byte_index,
  input  logic [7:0]       seed_byte,
  input  logic [CNT_W-1:0] bit_count,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      random_word
);

  // configuration
  logic [SEL_W-1:0] poly_a_select;
  logic [SEL_W-1:0] poly_b_select;

  // control
  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] got;
  logic [31:0]      word;
  logic             accept;
  logic             finish;
  logic             step;
  cell_ctl_t        ctl_a, ctl_b;
  logic             a_bit, b_bit, a_dead, b_dead_unused;
  logic [CNT_W-1:0] count_sat;

  assign accept = in_valid && in_ready;

  // counts above the word width saturate
  assign count_sat = (bit_count > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : bit_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_a_select <= '0;
      poly_b_select <= SEL_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POLY_A: poly_a_select <= cfg_data;
        REG_POLY_B: poly_b_select <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each LFSR is a row of byte cells; the carry runs from cell to cell.
  sg_lfsr u_lfsr_a (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl_a),
    .byte_index (byte_index),
    .seed_byte  (seed_byte),
    .poly       (poly_a_select),
    .next_bit   (a_bit),
    .dead       (a_dead)
  );

  sg_lfsr u_lfsr_b (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl_b),
    .byte_index (byte_index),
    .seed_byte  (seed_byte),
    .poly       (poly_b_select),
    .next_bit   (b_bit),
    .dead       (b_dead_unused)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = (state == ST_IDLE);
    ctl_a      = '0;
    ctl_b      = '0;
    finish     = 1'b0;
    step       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_LOAD_A: ctl_a.load = 1'b1;
            ACT_LOAD_B: ctl_b.load = 1'b1;
            ACT_CLEAR: begin
              ctl_a.clear = 1'b1;
              ctl_b.clear = 1'b1;
            end
            default: state_next = ST_RUN;
          endcase
        end
      end
      ST_RUN: begin
        if (got == cnt) begin
          // hold the finished word until the output register frees up
          if (!out_valid || out_ready) begin
            finish     = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          step        = 1'b1;
          ctl_a.shift = 1'b1;
          ctl_b.shift = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Shrinking rule: keep B's bit only when A gives a one.
  always_ff @(posedge clk) begin
    if (accept && action == ACT_GEN) begin
      cnt  <= a_dead ? '0 : count_sat;
      got  <= '0;
      word <= '0;
    end else if (step && a_bit) begin
      word[got[4:0]] <= b_bit;
      got            <= got + CNT_W'(1);
    end
  end

  // output register: the next item may be taken while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      random_word <= word;
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import sg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One request as it goes onto the input channel.
  typedef struct packed {
    action_t            act;
    logic [IDX_W-1:0]   idx;
    logic [7:0]         data;
    logic [CNT_W-1:0]   cnt;
  } ks_req_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic             cfg_index = 1'b0;
  logic [SEL_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       action = '0;
  logic [IDX_W-1:0] byte_index = '0;
  logic [7:0]       seed_byte = '0;
  logic [CNT_W-1:0] bit_count = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [31:0]      random_word;

  shrinking_generator_dual_lfsr dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .byte_index  (byte_index),
    .seed_byte   (seed_byte),
    .bit_count   (bit_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .random_word (random_word)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // ---------------------------------------------------------------
  // Keystream predictor: private copy of both seeds and selectors.
  // ---------------------------------------------------------------
  logic [SEED_BITS-1:0] ks_seed_a = '0;
  logic [SEED_BITS-1:0] ks_seed_b = '0;
  logic [SEL_W-1:0]     ks_sel_a = 4'd0;
  logic [SEL_W-1:0]     ks_sel_b = 4'd1;

  ks_req_t     req_queue[$];   // items waiting to be driven
  logic [31:0] want_words[$];  // predicted keystream words, oldest first

  int unsigned issued = 0;     // items put on the bus
  int unsigned accepted = 0;   // items taken by the block
  int unsigned mismatches = 0;
  bit          idle_on = 1'b1; // random gaps/stalls enabled

  // One Fibonacci step: XOR taps, shift left, feedback into bit 0.
  function automatic logic [SEED_BITS-1:0] lfsr_advance(input logic [SEED_BITS-1:0] r,
                                                        input int unsigned p);
    logic fb;
    fb = 1'b0;
    for (int i = 0; i < int'(TAP_COUNT[p]); i++) fb ^= r[TAPS[p][i]];
    return {r[SEED_BITS-2:0], fb};
  endfunction

  // Shrinking generator: B's bit kept only when A outputs 1.
  function automatic logic [31:0] keystream_word(input logic [CNT_W-1:0] cnt_in);
    int unsigned pa, pb, want, got, deg_a, deg_b;
    logic [SEED_BITS-1:0] win;
    logic [31:0] word;
    pa = ks_sel_a % POLY_COUNT;
    pb = ks_sel_b % POLY_COUNT;
    want = (cnt_in > MAX_BITS) ? MAX_BITS : cnt_in;
    deg_a = TAPS[pa][0];
    deg_b = TAPS[pb][0];
    // bits 0..degree of A; all zero means A never outputs a one
    win = ({{(SEED_BITS-1){1'b0}}, 1'b1} << (deg_a + 1)) - 1'b1;
    word = '0;
    got = 0;
    if (want != 0 && (ks_seed_a & win) != '0) begin
      while (got < want) begin
        ks_seed_a = lfsr_advance(ks_seed_a, pa);
        ks_seed_b = lfsr_advance(ks_seed_b, pb);
        if (ks_seed_a[deg_a]) begin
          word[got] = ks_seed_b[deg_b];
          got++;
        end
      end
    end
    return word;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Random idle length: mostly none, sometimes short, rarely long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // ---------------------------------------------------------------
  // Input side: acceptance/prediction at rising edge, drive at falling.
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      accepted++;
      case (action_t'(action))
        ACT_LOAD_A: if (byte_index < SEED_BYTES) ks_seed_a[int'(byte_index)*8 +: 8] = seed_byte;
        ACT_LOAD_B: if (byte_index < SEED_BYTES) ks_seed_b[int'(byte_index)*8 +: 8] = seed_byte;
        ACT_CLEAR: begin
          ks_seed_a = '0;
          ks_seed_b = '0;
        end
        default: want_words.push_back(keystream_word(bit_count));
      endcase
    end
  end

  int unsigned send_gap = 0;

  always @(negedge clk) begin
    ks_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && accepted != issued) begin
      // hold item until taken
    end else if (send_gap != 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (req_queue.size() != 0) begin
      req = req_queue.pop_front();
      action     <= req.act;
      byte_index <= req.idx;
      seed_byte  <= req.data;
      bit_count  <= req.cnt;
      in_valid   <= 1'b1;
      issued++;
      send_gap = pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------
  // Output side: random back-pressure, compare at rising edge.
  // ---------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    logic [31:0] exp_word;
    if (!rst && out_valid && out_ready) begin
      if (want_words.size() == 0) begin
        note_failure($sformatf("unexpected result: random_word %h", random_word));
      end else begin
        exp_word = want_words.pop_front();
        if (random_word !== exp_word)
          note_failure($sformatf("mismatch: random_word expected %h got %h",
                                 exp_word, random_word));
      end
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  task automatic push_req(input action_t a, input int idx, input int data, input int cnt);
    ks_req_t r;
    r.act  = a;
    r.idx  = IDX_W'(idx);
    r.data = 8'(data);
    r.cnt  = CNT_W'(cnt);
    req_queue.push_back(r);
  endtask

  // Wait until the block is idle with nothing outstanding.
  task automatic drain();
    while (req_queue.size() != 0 || in_valid || want_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t which, input logic [SEL_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (which == REG_POLY_A) ks_sel_a = val;
    else ks_sel_b = val;
  endtask

  // Config settings per phase: extremes, equal selectors, mixed.
  int sel_a_list[8] = '{15, 0, 13, 7, 10, 3, 9, 5};
  int sel_b_list[8] = '{14, 15, 0, 7, 13, 12, 1, 4};

  initial begin
    int r;
    int c;
    action_t la;

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed part, reset selectors (A=0, B=1).
    push_req(ACT_GEN, 0, 0, 5);        // all-zero A window: zero word
    push_req(ACT_GEN, 31, 255, 0);     // count of zero
    push_req(ACT_LOAD_A, 0, 8'h01, 0); // single bit: long wait for A's first one
    push_req(ACT_LOAD_B, 0, 8'hFF, 0);
    push_req(ACT_LOAD_B, 23, 8'hFF, 0);// top byte
    push_req(ACT_LOAD_B, 14, 8'hA5, 0);
    push_req(ACT_LOAD_A, 24, 8'hFF, 63); // index out of range: ignored
    push_req(ACT_LOAD_B, 31, 8'hFF, 0);
    push_req(ACT_GEN, 0, 0, 32);
    push_req(ACT_GEN, 0, 0, 1);
    push_req(ACT_GEN, 0, 0, 63);       // saturates to 32
    push_req(ACT_GEN, 0, 0, 33);
    push_req(ACT_LOAD_A, 23, 8'h80, 0);
    push_req(ACT_LOAD_B, 7, 8'h00, 0);
    push_req(ACT_CLEAR, 0, 0, 0);
    push_req(ACT_GEN, 0, 0, 8);        // dead after clear
    push_req(ACT_LOAD_A, 20, 8'h55, 0);
    push_req(ACT_LOAD_B, 5, 8'h3C, 0);
    push_req(ACT_GEN, 0, 0, 16);
    push_req(ACT_GEN, 0, 0, 0);
    push_req(ACT_LOAD_A, 3, 8'hFE, 0);
    push_req(ACT_GEN, 16, 8'hAA, 32);

    for (int ph = 0; ph < 8; ph++) begin
      // sender holds off until every result is back, then reconfigures
      drain();
      write_cfg(REG_POLY_A, SEL_W'(sel_a_list[ph]));
      write_cfg(REG_POLY_B, SEL_W'(sel_b_list[ph]));
      idle_on = (ph % 3 != 1);

      // fresh full seeds
      for (int k = 0; k < SEED_BYTES; k++) begin
        push_req(ACT_LOAD_A, k, $urandom_range(0, 255), $urandom_range(0, 63));
        push_req(ACT_LOAD_B, k, $urandom_range(0, 255), $urandom_range(0, 63));
      end

      for (int n = 0; n < 88; n++) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          c = $urandom_range(0, 19);
          if (c == 0) c = 0;
          else if (c == 1) c = $urandom_range(33, 63);
          else c = $urandom_range(1, 32);
          push_req(ACT_GEN, $urandom_range(0, 31), $urandom_range(0, 255), c);
        end else if (r < 88) begin
          la = r[0] ? ACT_LOAD_B : ACT_LOAD_A;
          c = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
          push_req(la, c, $urandom_range(0, 255), $urandom_range(0, 63));
        end else if (r < 91) begin
          // clear, then reseed low bytes so A is alive again
          push_req(ACT_CLEAR, $urandom_range(0, 31), $urandom_range(0, 255),
                   $urandom_range(0, 63));
          for (int k = 0; k < 3; k++)
            push_req(ACT_LOAD_A, $urandom_range(0, 13), $urandom_range(1, 255), 0);
          for (int k = 0; k < 2; k++)
            push_req(ACT_LOAD_B, $urandom_range(0, 23), $urandom_range(0, 255), 0);
        end else begin
          for (int k = 0; k < 4; k++) push_req(ACT_GEN, 0, 0, 32);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (want_words.size() != 0) note_failure("results missing at end of run");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
